[sv/tarc_pkg.sv]
// Shared types and constants for the triangle assembly / reject / cull block.
// Holds the vertex payload structs and the configuration register indexes.
// No dependencies.
package tarc_pkg;

    localparam int COORD_BITS_DEF = 32;

    // configuration register indexes
    localparam logic CFG_CULL_ENABLE  = 1'b0;
    localparam logic CFG_FRONT_SELECT = 1'b1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_w;
        logic        [15:0] color_red;
        logic        [15:0] color_green;
        logic        [15:0] color_blue;
        logic        [15:0] color_alpha;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic        [15:0] texture_index;
    } t_vtx_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic        [15:0] out_red;
        logic        [15:0] out_green;
        logic        [15:0] out_blue;
        logic        [15:0] out_alpha;
        logic signed [31:0] out_u;
        logic signed [31:0] out_v;
        logic        [15:0] out_texture;
        logic               last_vertex;
    } t_vtx_out;

endpackage

[sv/triangle_assembly_reject_cull.sv]
// Triangle assembly with trivial clip reject and back-face culling (top level).
// Depends on tarc_pkg for payload types and register indexes.
//
// Vertices are taken one per transfer; every third closes a triangle. When the
// third vertex closes a triangle with culling enabled, the sign of
// v0 . (v1 x v2) is found by one shared shift-and-add multiplier that runs nine
// serial multiplies of COORD_BITS steps each, each after a load state, and then
// a decision state; no vertex is taken meanwhile. A kept triangle then leaves
// as three vertex transfers from an output register, one per cycle when the
// receiver does not stall; the next vertex is taken after the third has been
// loaded into that register. Culling off: no multiply phase.
module triangle_assembly_reject_cull
    import tarc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_vtx_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_vtx_out o_out,
    input  logic     i_cfg_we,
    input  logic     i_cfg_index,
    input  logic     i_cfg_data
);

    localparam int ACC_W = 3 * COORD_BITS + 2;
    localparam int CNT_W = $clog2(COORD_BITS);

    typedef enum logic [2:0] {S_IN, S_LOAD, S_MUL, S_DEC, S_OUT} t_state;
    typedef enum logic [1:0] {PH_A, PH_B, PH_C} t_phase;

    t_state r_state;
    t_phase r_ph;
    logic [1:0] r_grp;
    logic [1:0] r_slot;
    logic       r_reject;
    logic       r_cull_enable;
    logic       r_front_select;
    logic [1:0] r_k;
    logic       r_out_valid;
    t_vtx_out   r_out;
    t_vtx_in    r_vtx [3];

    logic signed [ACC_W-1:0] r_mcand;
    logic        [COORD_BITS-1:0] r_mplier;
    logic        [CNT_W-1:0] r_bit;
    logic signed [ACC_W-1:0] r_tmp;
    logic signed [ACC_W-1:0] r_dot;

    logic signed [COORD_BITS-1:0] w_pos [3][4];
    logic signed [COORD_BITS-1:0] w_in_pos [4];
    logic signed [COORD_BITS:0]   w_in_w, w_in_nw;
    logic                         w_fail;
    logic                         w_in_xfer;
    logic                         w_out_free;
    logic signed [COORD_BITS-1:0] w_m, w_q;
    logic signed [ACC_W-1:0]      w_addend, w_target, w_sum;
    logic                         w_neg, w_last_bit, w_keep;

    assign o_in_stall  = (r_state != S_IN);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // the 32-bit field bits are the coordinate's low bits; wider coordinates zero-fill
    always_comb begin
        for (int v = 0; v < 3; v++) begin
            w_pos[v][0] = COORD_BITS'($unsigned(r_vtx[v].pos_x));
            w_pos[v][1] = COORD_BITS'($unsigned(r_vtx[v].pos_y));
            w_pos[v][2] = COORD_BITS'($unsigned(r_vtx[v].pos_z));
            w_pos[v][3] = COORD_BITS'($unsigned(r_vtx[v].pos_w));
        end
        w_in_pos[0] = COORD_BITS'($unsigned(i_in.pos_x));
        w_in_pos[1] = COORD_BITS'($unsigned(i_in.pos_y));
        w_in_pos[2] = COORD_BITS'($unsigned(i_in.pos_z));
        w_in_pos[3] = COORD_BITS'($unsigned(i_in.pos_w));
    end

    // strict clip test: -w < c < w for x, y, z
    always_comb begin
        w_in_w  = (COORD_BITS+1)'(w_in_pos[3]);
        w_in_nw = -w_in_w;
        w_fail  = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (!((COORD_BITS+1)'(w_in_pos[a]) > w_in_nw &&
                  (COORD_BITS+1)'(w_in_pos[a]) < w_in_w)) begin
                w_fail = 1'b1;
            end
        end
    end

    // operand schedule: cross term = m1*q1 - m2*q2, then dot += v0 axis * cross
    always_comb begin
        w_m = w_pos[1][0];
        w_q = w_pos[2][0];
        case ({r_grp, r_ph})
            {2'd0, PH_A}: begin w_m = w_pos[1][1]; w_q = w_pos[2][2]; end
            {2'd0, PH_B}: begin w_m = w_pos[1][2]; w_q = w_pos[2][1]; end
            {2'd0, PH_C}: begin w_m = w_pos[1][0]; w_q = w_pos[0][0]; end
            {2'd1, PH_A}: begin w_m = w_pos[1][2]; w_q = w_pos[2][0]; end
            {2'd1, PH_B}: begin w_m = w_pos[1][0]; w_q = w_pos[2][2]; end
            {2'd1, PH_C}: begin w_m = w_pos[1][0]; w_q = w_pos[0][1]; end
            {2'd2, PH_A}: begin w_m = w_pos[1][0]; w_q = w_pos[2][1]; end
            {2'd2, PH_B}: begin w_m = w_pos[1][1]; w_q = w_pos[2][0]; end
            {2'd2, PH_C}: begin w_m = w_pos[1][0]; w_q = w_pos[0][2]; end
            default:      begin w_m = w_pos[1][0]; w_q = w_pos[2][0]; end
        endcase
    end

    // shared shift-and-add step; multiplier MSB carries negative weight
    always_comb begin
        w_last_bit = (r_bit == CNT_W'(COORD_BITS - 1));
        w_addend   = r_mplier[0] ? r_mcand : '0;
        w_neg      = w_last_bit ^ (r_ph == PH_B);
        w_target   = (r_ph == PH_C) ? r_dot : r_tmp;
        w_sum      = w_neg ? (w_target - w_addend) : (w_target + w_addend);
        w_keep     = r_front_select ? (r_dot != '0 && !r_dot[ACC_W-1])
                                    : r_dot[ACC_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IN;
            r_slot         <= '0;
            r_reject       <= 1'b0;
            r_cull_enable  <= 1'b0;
            r_front_select <= 1'b0;
            r_out_valid    <= 1'b0;
            r_k            <= '0;
            r_grp          <= '0;
            r_ph           <= PH_A;
            r_bit          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CULL_ENABLE:  r_cull_enable  <= i_cfg_data;
                    CFG_FRONT_SELECT: r_front_select <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IN: begin
                    if (w_in_xfer) begin
                        if (r_slot < 2'd2) begin
                            r_vtx[r_slot] <= i_in;
                            r_slot        <= r_slot + 2'd1;
                            r_reject      <= r_reject | w_fail;
                        end else begin
                            r_vtx[2]  <= i_in;
                            r_slot    <= '0;
                            r_reject  <= 1'b0;
                            r_k       <= '0;
                            r_grp     <= '0;
                            r_ph      <= PH_A;
                            r_dot     <= '0;
                            if (w_fail || r_reject) begin
                                r_state <= S_IN;
                            end else if (r_cull_enable) begin
                                r_state <= S_LOAD;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                    end
                end
                S_LOAD: begin
                    r_mcand  <= (r_ph == PH_C) ? r_tmp : ACC_W'(w_m);
                    r_mplier <= w_q;
                    r_bit    <= '0;
                    if (r_ph == PH_A) begin
                        r_tmp <= '0;
                    end
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    if (r_ph == PH_C) begin
                        r_dot <= w_sum;
                    end else begin
                        r_tmp <= w_sum;
                    end
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                    r_bit    <= r_bit + 1'b1;
                    if (w_last_bit) begin
                        if (r_ph == PH_C) begin
                            r_ph    <= PH_A;
                            r_grp   <= r_grp + 2'd1;
                            r_state <= (r_grp == 2'd2) ? S_DEC : S_LOAD;
                        end else begin
                            r_ph    <= (r_ph == PH_A) ? PH_B : PH_C;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DEC: begin
                    r_state <= w_keep ? S_OUT : S_IN;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out.out_x       <= 32'(w_pos[r_k][0]);
                        r_out.out_y       <= 32'(w_pos[r_k][1]);
                        r_out.out_z       <= 32'(w_pos[r_k][2]);
                        r_out.out_w       <= 32'(w_pos[r_k][3]);
                        r_out.out_red     <= r_vtx[r_k].color_red;
                        r_out.out_green   <= r_vtx[r_k].color_green;
                        r_out.out_blue    <= r_vtx[r_k].color_blue;
                        r_out.out_alpha   <= r_vtx[r_k].color_alpha;
                        r_out.out_u       <= r_vtx[r_k].tex_u;
                        r_out.out_v       <= r_vtx[r_k].tex_v;
                        r_out.out_texture <= r_vtx[2].texture_index;
                        r_out.last_vertex <= (r_k == 2'd2);
                        r_k               <= r_k + 2'd1;
                        if (r_k == 2'd2) begin
                            r_state <= S_IN;
                        end
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3) else $error("slot count out of range");

    a_out_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_OUT ##1 r_state == S_OUT) |-> r_k == 2'd0)
        else $error("triangle output does not start at first vertex");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("pending vertex dropped");

    a_mul_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_LOAD) |-> r_grp != 2'd3)
        else $error("multiply schedule overran");

endmodule
